/* src/ujesc_pkg.sv */
// ============================================================================
// ujesc_pkg
// Shared types, character constants and helpers of the UTF-8 to JSON escaper.
// ============================================================================
package ujesc_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 16;

    // Kind of work handed from the front part to the back part.
    typedef enum logic [1:0] {
        JOB_PLAIN = 2'd0,   // one character, passed as is
        JOB_ESC   = 2'd1,   // backslash plus one escape letter
        JOB_UNI   = 2'd2    // backslash, 'u' and four hex digits
    } job_kind_t;

    // For plain and two-character jobs the character sits in the low byte.
    typedef struct packed {
        job_kind_t           kind;
        logic [CODE_W-1:0]   data;
    } job_t;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_BS        = 8'h08;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_FF        = 8'h0C;
    localparam logic [BYTE_W-1:0] LEAD_LO      = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_HI      = 8'hFD;

    // Lowercase hex digit of one nibble.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10)
        begin
            hex_char = 8'h30 + wide;
        end
        else
        begin
            hex_char = 8'h57 + wide;
        end
    endfunction

endpackage

/* src/ujesc_front.sv */
// ============================================================================
// ujesc_front
// Accepts input bytes, tracks multi-byte sequences and issues escape jobs.
// ============================================================================
module ujesc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [ujesc_pkg::BYTE_W-1:0] in_byte,
    input  logic                      in_end,
    input  logic                      queue_full,
    output logic                      in_ready,
    output logic                      job_push,
    output ujesc_pkg::job_t           job
);
    import ujesc_pkg::*;

    logic [2:0]        pend_reg,  pend_next;
    logic [CODE_W-1:0] accum_reg, accum_next;
    logic              take;
    logic [2:0]        cnt;
    logic [BYTE_W-1:0] lead_mask;
    logic [CODE_W-1:0] shifted;
    logic [2:0]        pend_dec;

    assign in_ready = !queue_full;
    assign take     = in_valid && !queue_full;
    assign shifted  = {accum_reg[CODE_W-7:0], in_byte[5:0]};
    assign pend_dec = pend_reg - 3'd1;

    // Continuation count from the lead byte's top bits.
    always_comb
    begin
        if (in_byte >= 8'hFC)
        begin
            cnt = 3'd5;
        end
        else if (in_byte >= 8'hF8)
        begin
            cnt = 3'd4;
        end
        else if (in_byte >= 8'hF0)
        begin
            cnt = 3'd3;
        end
        else if (in_byte >= 8'hE0)
        begin
            cnt = 3'd2;
        end
        else
        begin
            cnt = 3'd1;
        end
        lead_mask = 8'hFF >> ({5'd0, cnt} + 8'd2);
    end

    always_comb
    begin
        pend_next  = pend_reg;
        accum_next = accum_reg;
        job_push   = 1'b0;
        job.kind   = JOB_PLAIN;
        job.data   = {8'd0, in_byte};
        if (take)
        begin
            if (pend_reg != 3'd0)
            begin
                if (pend_dec == 3'd0 || in_end)
                begin
                    job_push   = 1'b1;
                    job.kind   = JOB_UNI;
                    job.data   = shifted;
                    pend_next  = 3'd0;
                    accum_next = '0;
                end
                else
                begin
                    pend_next  = pend_dec;
                    accum_next = shifted;
                end
            end
            else if (in_byte inside {[LEAD_LO:LEAD_HI]})
            begin
                if (in_end)
                begin
                    job_push = 1'b1;
                    job.kind = JOB_UNI;
                    job.data = {8'd0, in_byte & lead_mask};
                end
                else
                begin
                    pend_next  = cnt;
                    accum_next = {8'd0, in_byte & lead_mask};
                end
            end
            else
            begin
                job_push = 1'b1;
                case (in_byte)
                    CH_QUOTE:
                    begin
                        job.kind = JOB_ESC;
                        job.data = {8'd0, CH_QUOTE};
                    end
                    CH_TAB:
                    begin
                        job.kind = JOB_ESC;
                        job.data = {8'd0, 8'h74};
                    end
                    CH_BS:
                    begin
                        job.kind = JOB_ESC;
                        job.data = {8'd0, 8'h62};
                    end
                    CH_CR:
                    begin
                        job.kind = JOB_ESC;
                        job.data = {8'd0, 8'h72};
                    end
                    CH_FF:
                    begin
                        job.kind = JOB_ESC;
                        job.data = {8'd0, 8'h66};
                    end
                    default:
                    begin
                        job.kind = JOB_PLAIN;
                        job.data = {8'd0, in_byte};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 3'd0;
            accum_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            accum_reg <= accum_next;
        end
    end

endmodule

/* src/ujesc_fifo.sv */
// ============================================================================
// ujesc_fifo
// Short job queue between the front and back parts, head read directly.
// ============================================================================
module ujesc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ujesc_pkg::job_t  push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output ujesc_pkg::job_t  head
);
    import ujesc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/ujesc_back.sv */
// ============================================================================
// ujesc_back
// Expands queued jobs into output characters, one per cycle while the receiver is ready, registered.
// ============================================================================
module ujesc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_avail,
    input  ujesc_pkg::job_t              job,
    output logic                         job_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ujesc_pkg::BYTE_W-1:0] out_char,
    output logic                         out_last
);
    import ujesc_pkg::*;

    logic [2:0]        idx_reg,   idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] char_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] cur_char;
    logic [2:0]        final_idx;
    logic              is_final;
    logic              load;

    assign load      = job_avail && (!valid_reg || out_ready);
    assign is_final  = (idx_reg == final_idx);
    assign job_pop   = load && is_final;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        final_idx = 3'd0;
        cur_char  = job.data[BYTE_W-1:0];
        case (job.kind)
            JOB_PLAIN:
            begin
                final_idx = 3'd0;
                cur_char  = job.data[BYTE_W-1:0];
            end
            JOB_ESC:
            begin
                final_idx = 3'd1;
                cur_char  = (idx_reg == 3'd0) ? CH_BACKSLASH : job.data[BYTE_W-1:0];
            end
            JOB_UNI:
            begin
                final_idx = 3'd5;
                case (idx_reg)
                    3'd0:    cur_char = CH_BACKSLASH;
                    3'd1:    cur_char = CH_U;
                    3'd2:    cur_char = hex_char(job.data[15:12]);
                    3'd3:    cur_char = hex_char(job.data[11:8]);
                    3'd4:    cur_char = hex_char(job.data[7:4]);
                    default: cur_char = hex_char(job.data[3:0]);
                endcase
            end
            default:
            begin
                final_idx = 3'd0;
                cur_char  = job.data[BYTE_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_final ? 3'd0 : idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= cur_char;
            last_reg <= is_final;
        end
    end

endmodule

/* src/utf8_to_json_unicode_escaper.sv */
// ============================================================================
// utf8_to_json_unicode_escaper
// Escapes the body of a JSON string from raw UTF-8 bytes, one byte a request.
// ============================================================================
// Usage:
//   Input stream (s_*): one raw byte per request in s_tdata; s_tlast marks the
//   final byte of the string. Output stream (m_*): one escaped character per
//   request in m_tdata; m_tlast marks the final character caused by one
//   input byte. Lead bytes 0xC0..0xFD and their continuation bytes give no
//   output until the sequence completes (or the string ends), then a six
//   character \uXXXX escape of the low 16 bits of the code point follows.
//   Quote, tab, backspace, CR and FF become two-character escapes.
//
// Timing:
//   The front part classifies a byte in the cycle it is accepted and writes
//   a job into a queue of FIFO_DEPTH entries. The back part turns the job at
//   the queue head into characters at one per cycle while m_tready is high,
//   into an output register, so the first character of a byte passes through
//   the queue and then the output register before it is valid. Throughput is
//   set by the output; the front keeps taking bytes while the back expands
//   earlier jobs, until the queue is full.
//
// Reset clears the sequence state, the queue and the output valid flag.
// When the receiver stalls, the output register holds its character, the
// queue fills, and s_tready drops only once the queue is full.
// ============================================================================
module utf8_to_json_unicode_escaper #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] byte_in
    input  logic       s_tlast,    // string_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic       m_tlast     // last_of_run
);
    import ujesc_pkg::*;

    job_t front_job;
    job_t head_job;
    logic job_push;
    logic job_pop;
    logic q_full;
    logic q_empty;

    // Front: sequence tracking and classification of each accepted byte.
    ujesc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .queue_full (q_full),
        .in_ready   (s_tready),
        .job_push   (job_push),
        .job        (front_job)
    );

    // Queue that decouples byte intake from character output.
    ujesc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (front_job),
        .pop       (job_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head_job)
    );

    // Back: expands the head job into characters on the output stream.
    ujesc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (head_job),
        .job_pop   (job_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
